FILE: rtl/mds_pkg.sv
// shared types, codes and defaults for the multi deque store
`timescale 1ns / 1ps

package mds_pkg;

   localparam int NUM_BARRELS_DEF = 16;
   localparam int CAPACITY_DEF    = 64;
   localparam int DATA_WIDTH_DEF  = 64;

   localparam int VALUE_W  = 64;
   localparam int BARREL_W = 5;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 5;

   localparam logic [CSR_W-1:0] ACTIVE_RESET = 5'd16;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

   localparam logic OP_STORE    = 1'b0;
   localparam logic OP_RETRIEVE = 1'b1;
   localparam logic END_FRONT   = 1'b0;
   localparam logic END_BACK    = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [VALUE_W-1:0]  value;
      logic                end_select;
      logic [BARREL_W-1:0] barrel;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  popped_value;
   } rsp_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_DELIVER
   } ctl_state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } dp_sts_type;

endpackage

FILE: rtl/mds_ctrl.sv
// controller state machine sequencing one item through the datapath
`timescale 1ns / 1ps

module mds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mds_pkg::dp_sts_type  sts,
   output mds_pkg::ctl_cmd_type cmd
);

   mds_pkg::ctl_state_type state_ff;
   mds_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mds_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mds_pkg::CTL_IDLE: begin
            if (req_valid) begin
               state_in = mds_pkg::CTL_EXEC;
            end
         end
         mds_pkg::CTL_EXEC: begin
            state_in = mds_pkg::CTL_DELIVER;
         end
         mds_pkg::CTL_DELIVER: begin
            if (sts.rsp_free) begin
               state_in = mds_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = mds_pkg::CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         mds_pkg::CTL_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         mds_pkg::CTL_EXEC: begin
            cmd.exec = 1'b1;
         end
         mds_pkg::CTL_DELIVER: begin
            cmd.load_rsp = sts.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/mds_datapath.sv
// barrel tables, entry memory, slot arithmetic and result register
`timescale 1ns / 1ps

module mds_datapath #(
   parameter int NUM_BARRELS = mds_pkg::NUM_BARRELS_DEF,
   parameter int CAPACITY    = mds_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH  = mds_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mds_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mds_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mds_pkg::CSR_W-1:0]         csr_data,
   input  mds_pkg::ctl_cmd_type              cmd,
   output mds_pkg::dp_sts_type               sts
);

   localparam int BW    = (NUM_BARRELS > 1) ? $clog2(NUM_BARRELS) : 1;
   localparam int SW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int SUMW  = $clog2(2 * CAPACITY);
   localparam int DEPTH = NUM_BARRELS * CAPACITY;
   localparam int AW    = $clog2(DEPTH);
   localparam int LIMW  = ($clog2(NUM_BARRELS + 1) > mds_pkg::BARREL_W) ?
                          $clog2(NUM_BARRELS + 1) : mds_pkg::BARREL_W;

   localparam logic [LIMW-1:0] NumLim  = LIMW'(NUM_BARRELS);
   localparam logic [SW-1:0]   LastSl  = SW'(CAPACITY - 1);
   localparam logic [CW-1:0]   CapCnt  = CW'(CAPACITY);
   localparam logic [SUMW-1:0] CapSum  = SUMW'(CAPACITY);
   localparam logic [AW-1:0]   CapAddr = AW'(CAPACITY);

   logic [mds_pkg::CSR_W-1:0] active_ff;
   mds_pkg::req_type          req_ff;
   logic [SW-1:0]             head_ff  [NUM_BARRELS];
   logic [CW-1:0]             count_ff [NUM_BARRELS];
   logic [DATA_WIDTH-1:0]     mem      [DEPTH];
   logic [DATA_WIDTH-1:0]     rd_data_ff;
   logic [mds_pkg::STATUS_W-1:0] status_ff;
   logic                      pop_ok_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   mds_pkg::rsp_type          rsp_ff;

   logic [LIMW-1:0]           limit;
   logic [LIMW-1:0]           barrel_ext;
   logic                      barrel_ok;
   logic [BW-1:0]             bidx;
   logic [SW-1:0]             head;
   logic [CW-1:0]             count;
   logic [CW-1:0]             offset;
   logic [SUMW-1:0]           sum;
   logic [SW-1:0]             back_slot;
   logic [SW-1:0]             slot;
   logic [SW-1:0]             head_in;
   logic [CW-1:0]             count_in;
   logic                      upd;
   logic                      mem_we;
   logic                      mem_re;
   logic [mds_pkg::STATUS_W-1:0] status_in;
   logic [AW-1:0]             addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= mds_pkg::ACTIVE_RESET;
      end else if (csr_valid) begin
         active_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // barrel check and slot arithmetic
   always_comb begin
      barrel_ext = LIMW'(req_ff.barrel);
      limit      = (LIMW'(active_ff) > NumLim) ? NumLim : LIMW'(active_ff);
      barrel_ok  = (req_ff.barrel != '0) && (barrel_ext <= limit);
      bidx       = BW'(barrel_ext - LIMW'(1));
      head       = head_ff[bidx];
      count      = count_ff[bidx];
      offset     = (req_ff.operation == mds_pkg::OP_RETRIEVE) ? count - CW'(1) : count;
      sum        = SUMW'(head) + SUMW'(offset);
      back_slot  = (sum >= CapSum) ? SW'(sum - CapSum) : SW'(sum);

      status_in = mds_pkg::STATUS_OK;
      slot      = back_slot;
      head_in   = head;
      count_in  = count;
      upd       = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;

      if (!barrel_ok) begin
         status_in = mds_pkg::STATUS_BAD;
      end else if (req_ff.operation == mds_pkg::OP_STORE) begin
         if (count == CapCnt) begin
            status_in = mds_pkg::STATUS_FULL;
         end else begin
            upd      = 1'b1;
            mem_we   = 1'b1;
            count_in = count + CW'(1);
            if (req_ff.end_select == mds_pkg::END_FRONT) begin
               slot    = (head == '0) ? LastSl : head - SW'(1);
               head_in = slot;
            end
         end
      end else begin
         if (count == '0) begin
            status_in = mds_pkg::STATUS_EMPTY;
         end else begin
            upd      = 1'b1;
            mem_re   = 1'b1;
            count_in = count - CW'(1);
            if (req_ff.end_select == mds_pkg::END_FRONT) begin
               slot    = head;
               head_in = (head == LastSl) ? '0 : head + SW'(1);
            end
         end
      end

      addr = AW'(bidx) * CapAddr + AW'(slot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BARRELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (cmd.exec && upd) begin
         head_ff[bidx]  <= head_in;
         count_ff[bidx] <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && mem_we) begin
         mem[addr] <= req_ff.value[DATA_WIDTH-1:0];
      end
      if (cmd.exec && mem_re) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= mem_re;
      end
   end

   // result register
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.popped_value <= pop_ok_ff ? mds_pkg::VALUE_W'(rd_data_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/multi_deque_store_unit.sv
// top level of the multi deque store: controller plus datapath
`timescale 1ns / 1ps

// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------
// req       | req_valid / req_stall | req_data: operation, value, end, barrel
// rsp       | rsp_valid / rsp_stall | rsp_data: status, popped_value
// csr       | csr_valid / csr_ready | csr_data: active barrel count
//
// items one at a time: accept, table lookup with memory access, then result load
// the registered read port of the entry memory sets the middle step
// a held result does not block the next accept; a stalled result delays delivery
// synchronous reset clears heads and counts and sets 16 active barrels; entries stay unset

module multi_deque_store_unit #(
   parameter int NUM_BARRELS = mds_pkg::NUM_BARRELS_DEF,
   parameter int CAPACITY    = mds_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH  = mds_pkg::DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mds_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mds_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [mds_pkg::CSR_W-1:0] csr_data
);

   mds_pkg::ctl_cmd_type cmd;
   mds_pkg::dp_sts_type  sts;

   mds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mds_datapath #(
      .NUM_BARRELS (NUM_BARRELS),
      .CAPACITY    (CAPACITY),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in flight");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != mds_pkg::STATUS_OK |-> rsp_data.popped_value == '0)
      else $error("non-zero value on an error result");

   a_exec_order: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec && !cmd.load_req)
      else $error("execute step not followed by delivery");

endmodule

FILE: tb/tb.sv
// self-checking testbench for multi_deque_store_unit with its own deque predictor
`timescale 1ns / 1ps

module tb;
   import mds_pkg::*;

   localparam int NB    = NUM_BARRELS_DEF;
   localparam int CAP   = CAPACITY_DEF;
   localparam int PTR_W = $clog2(CAP);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   multi_deque_store_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [VALUE_W-1:0] slot_mem [NB][CAP];
   logic [PTR_W-1:0]   front_ptr [NB];
   logic [PTR_W:0]     fill_level [NB];
   logic [CSR_W-1:0]   barrel_limit = ACTIVE_RESET;

   req_type pending_items [$];
   rsp_type expected_rsps [$];

   int  mismatches = 0;
   int  stim_hi = NB;
   bit  no_idle = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  req_taken = 1'b0;

   initial begin
      for (int b = 0; b < NB; b++) begin
         front_ptr[b]  = '0;
         fill_level[b] = '0;
      end
   end

   function automatic rsp_type deque_step(req_type r);
      rsp_type          o;
      int               lim;
      int               b;
      logic [PTR_W-1:0] h;
      logic [PTR_W-1:0] slot;
      logic [PTR_W:0]   c;
      o.status       = STATUS_OK;
      o.popped_value = '0;
      lim = (barrel_limit > NB) ? NB : barrel_limit;
      if (r.barrel == 0 || r.barrel > lim) begin
         o.status = STATUS_BAD;
      end else begin
         b = r.barrel - 1;
         h = front_ptr[b];
         c = fill_level[b];
         if (r.operation == OP_STORE) begin
            if (c >= CAP) begin
               o.status = STATUS_FULL;
            end else begin
               if (r.end_select == END_BACK) begin
                  slot = h + c[PTR_W-1:0];
               end else begin
                  h = h - 1'b1;
                  slot = h;
                  front_ptr[b] = h;
               end
               slot_mem[b][slot] = r.value;
               fill_level[b] = c + 1'b1;
            end
         end else begin
            if (c == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               if (r.end_select == END_BACK) begin
                  slot = h + c[PTR_W-1:0] - 1'b1;
               end else begin
                  slot = h;
                  front_ptr[b] = h + 1'b1;
               end
               o.popped_value = slot_mem[b][slot];
               fill_level[b] = c - 1'b1;
            end
         end
      end
      return o;
   endfunction

   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_item(logic op, logic [VALUE_W-1:0] v, logic e, int b);
      req_type r;
      r.operation  = op;
      r.value      = v;
      r.end_select = e;
      r.barrel     = b[BARREL_W-1:0];
      pending_items = {pending_items, r};
   endtask

   // bursts on one barrel, some running past full or empty, with some stray barrels mixed in
   task automatic queue_traffic(int n);
      int added;
      int kind;
      int b;
      int len;
      added = 0;
      while (added < n) begin
         kind = $urandom_range(0, 9);
         b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, stim_hi);
         if (kind < 2) begin
            len = CAP + $urandom_range(1, 4);
            repeat (len) add_item(OP_STORE, rand_value(), 1'($urandom_range(0, 1)), b);
         end else if (kind < 4) begin
            len = $urandom_range(8, CAP + 4);
            repeat (len) add_item(OP_RETRIEVE, rand_value(), 1'($urandom_range(0, 1)), b);
         end else begin
            len = 16;
            repeat (len) begin
               add_item(($urandom_range(0, 99) < 55) ? OP_STORE : OP_RETRIEVE, rand_value(),
                        1'($urandom_range(0, 1)),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : b);
            end
         end
         added += len;
      end
   endtask

   task automatic wait_quiet();
      while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(logic [CSR_W-1:0] v);
      wait_quiet();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // item driver
   always @(negedge clock) begin : drive_req
      logic    nv;
      req_type nd;
      nv = req_valid;
      nd = req_data;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_valid || req_taken) begin
         nv = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_items.size() > 0) begin
            nd = pending_items[0];
            pending_items.delete(0);
            nv = 1'b1;
            send_gap = gap_len();
         end
      end
      req_valid <= nv;
      req_data  <= nd;
   end

   // result receiver back-pressure
   always @(negedge clock) begin : drive_stall
      logic ns;
      ns = 1'b0;
      if (hold_request && hold_left == 0) begin
         hold_left = 250;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         ns = 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         ns = 1'b1;
         stall_left--;
      end else begin
         stall_left = gap_len();
         if (stall_left > 0) begin
            ns = 1'b1;
            stall_left--;
         end
      end
      rsp_stall <= ns;
   end

   // monitor: prediction on accept, checking on delivery
   always @(posedge clock) begin : observe
      rsp_type want;
      rsp_type pred;
      req_taken = req_valid && !req_stall;
      if (!reset) begin
         if (csr_valid && csr_ready) barrel_limit = csr_data;
         if (req_taken) begin
            pred = deque_step(req_data);
            expected_rsps = {expected_rsps, pred};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item: status %0d value %h",
                           rsp_data.status, rsp_data.popped_value);
            end else begin
               want = expected_rsps[0];
               expected_rsps.delete(0);
               if (rsp_data.status !== want.status ||
                   rsp_data.popped_value !== want.popped_value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                              want.status, rsp_data.status,
                              want.popped_value, rsp_data.popped_value);
               end
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: limits, both ends, empty and bad barrels
      add_item(OP_RETRIEVE, '0, END_FRONT, 1);
      add_item(OP_RETRIEVE, '0, END_BACK, 16);
      add_item(OP_STORE, '1, END_FRONT, 0);
      add_item(OP_RETRIEVE, '0, END_BACK, 17);
      add_item(OP_STORE, '1, END_BACK, 31);
      add_item(OP_STORE, '0, END_FRONT, 1);
      add_item(OP_STORE, '1, END_BACK, 1);
      add_item(OP_STORE, 64'hA5A5_A5A5_A5A5_A5A5, END_FRONT, 1);
      add_item(OP_STORE, 64'h8000_0000_0000_0001, END_BACK, 16);
      add_item(OP_RETRIEVE, '1, END_BACK, 1);
      add_item(OP_RETRIEVE, '0, END_FRONT, 1);
      add_item(OP_RETRIEVE, '0, END_FRONT, 1);
      add_item(OP_RETRIEVE, '0, END_BACK, 1);
      add_item(OP_STORE, 64'h5555_5555_5555_5555, END_FRONT, 16);
      add_item(OP_RETRIEVE, '0, END_FRONT, 16);
      add_item(OP_RETRIEVE, '0, END_FRONT, 16);
      add_item(OP_RETRIEVE, '0, END_BACK, 16);
      add_item(OP_STORE, rand_value(), END_BACK, 8);
      add_item(OP_RETRIEVE, '0, END_FRONT, 8);
      queue_traffic(150);

      write_limit(5'd1);
      stim_hi = 2;
      queue_traffic(100);

      write_limit(5'd0);
      stim_hi = NB;
      queue_traffic(30);

      write_limit(5'd31);
      queue_traffic(150);

      // long receiver hold-off while items keep coming
      write_limit(5'd16);
      hold_request = 1'b1;
      queue_traffic(150);

      write_limit(CSR_W'($urandom_range(2, 15)));
      stim_hi = barrel_limit + 1;
      queue_traffic(120);

      write_limit(5'd16);
      stim_hi = NB;
      no_idle = 1'b1;
      queue_traffic(100);

      wait_quiet();
      repeat (20) @(posedge clock);
      mismatches += expected_rsps.size();
      if (mismatches == 0)
         $display("[multi_deque_store_unit] OK");
      else
         $display("[multi_deque_store_unit] ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[multi_deque_store_unit] ERROR");
      $finish;
   end

endmodule
